[src/modular_inverse_by_exponentiation_defines.svh]
// Assertion macros for the modular inverse block
`ifndef MODULAR_INVERSE_BY_EXPONENTIATION_DEFINES_SVH
`define MODULAR_INVERSE_BY_EXPONENTIATION_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define MIE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/mie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;
    localparam logic [1:0] CFG_MODULUS   = 2'd0;
    localparam logic [1:0] CFG_COMPOSITE = 2'd1;
    localparam logic [1:0] CFG_TOTIENT   = 2'd2;

    typedef struct packed {
        logic load;
        logic start_mul;
        logic sel_base;
        logic use_one;
    } mie_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic red_done;
    } mie_status_t;
endpackage
`default_nettype wire

[src/mie_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module mie_datapath #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mie_pkg::mie_cmd_t    cmd,
    input  wire logic [WORD_BITS-1:0] key,
    input  wire logic [WORD_BITS-1:0] modulus,
    output mie_pkg::mie_status_t      status,
    output logic [WORD_BITS-1:0]      acc
);
    import mie_pkg::*;

    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] p_reg, p_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 red_reg, red_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   dbl, dsum;
    logic [WORD_BITS:0]   addend;
    logic [WORD_BITS-1:0] r1;

    // one conditional subtraction of m (single reduction step)
    function automatic logic [WORD_BITS-1:0] red1(input logic [WORD_BITS:0] v,
                                                  input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] d;
        d = v - {1'b0, m};
        red1 = d[WORD_BITS] ? v[WORD_BITS-1:0] : d[WORD_BITS-1:0];
    endfunction

    always_comb
    begin
        dbl    = {1'b0, red1({p_reg, 1'b0}, modulus)};
        addend = b_reg[WORD_BITS-1] ? {1'b0, a_reg} : '0;
        dsum   = dbl + addend;
        r1     = red1(dsum, modulus);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        base_next = base_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        red_next  = red_reg;
        done_next = 1'b0;
        if (cmd.load)
        begin
            // reduce key: b = key, a = 0; key bits are shifted into p modulo m
            a_next    = '0;
            p_next    = '0;
            b_next    = key;
            red_next  = 1'b1;
            busy_next = 1'b1;
            cnt_next  = CW'(WORD_BITS);
            acc_next  = (modulus > WORD_BITS'(1)) ? WORD_BITS'(1) : '0;
        end
        else if (cmd.start_mul)
        begin
            a_next    = cmd.sel_base ? base_reg : acc_reg;
            b_next    = acc_reg;
            p_next    = '0;
            busy_next = 1'b1;
            cnt_next  = CW'(WORD_BITS);
        end
        else if (busy_reg)
        begin
            if (red_reg)
            begin
                // key mod m: p = 2p + bit, then reduce
                p_next = red1({p_reg, b_reg[WORD_BITS-1]}, modulus);
            end
            else
            begin
                p_next = r1;
            end
            b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        if (done_reg && !cmd.load)
        begin
            if (red_reg)
            begin
                base_next = p_reg;
                red_next  = 1'b0;
            end
            else
            begin
                acc_next = p_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            red_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            red_reg  <= red_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        p_reg    <= p_next;
    end

    assign status.mul_done = done_reg & ~red_reg;
    assign status.red_done = done_reg & red_reg;
    assign acc = cmd.use_one ? acc_reg : acc_reg;
endmodule
`default_nettype wire

[src/mie_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
module mie_controller #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 key_valid,
    output logic                      key_ready,
    output logic                      inverse_valid,
    input  wire logic                 inverse_ready,
    input  wire logic [WORD_BITS-1:0] exponent,
    input  wire logic                 mod_small,
    input  wire mie_pkg::mie_status_t status,
    output mie_pkg::mie_cmd_t         cmd
);
    import mie_pkg::*;

    localparam int BW = $clog2(WORD_BITS);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic                 issued_reg, issued_next;
    logic                 mul_reg, mul_next;

    always_comb
    begin
        state_next    = state_reg;
        bit_next      = bit_reg;
        exp_next      = exp_reg;
        issued_next   = issued_reg;
        mul_next      = mul_reg;
        cmd           = '0;
        key_ready     = (state_reg == S_IDLE);
        inverse_valid = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (key_valid)
                begin
                    cmd.load   = 1'b1;
                    exp_next   = exponent;
                    bit_next   = BW'(WORD_BITS - 1);
                    state_next = mod_small ? S_OUT : S_RED;
                end
            end
            S_RED:
            begin
                if (status.red_done)
                begin
                    issued_next = 1'b0;
                    state_next  = S_SQ;
                end
            end
            S_SQ:
            begin
                if (!issued_reg)
                begin
                    cmd.start_mul = 1'b1;
                    issued_next   = 1'b1;
                    mul_next      = 1'b0;
                    state_next    = S_WAIT;
                end
            end
            S_MUL:
            begin
                cmd.start_mul = 1'b1;
                cmd.sel_base  = 1'b1;
                mul_next      = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.mul_done)
                begin
                    issued_next = 1'b0;
                    if (!mul_reg && exp_reg[bit_reg])
                    begin
                        state_next = S_MUL;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BW'(1);
                        state_next = S_SQ;
                    end
                end
            end
            S_OUT:
            begin
                cmd.use_one = 1'b1;
                if (inverse_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bit_reg    <= '0;
            issued_reg <= 1'b0;
            mul_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bit_reg    <= bit_next;
            issued_reg <= issued_next;
            mul_reg    <= mul_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
    end
endmodule
`default_nettype wire

[src/modular_inverse_by_exponentiation.sv]
// Channel   | Handshake                     | Payload
// key       | key_valid / key_ready         | key[63:0]
// inverse   | inverse_valid / inverse_ready | inverse[63:0]
// cfg       | cfg_valid / cfg_ready         | cfg_index[1:0], cfg_data[63:0]
// One item at a time: the key is reduced first, then one square per exponent
// bit and one multiply per set bit, each through the shared shift-subtract
// unit. Reset clears control state only; config registers reset to 2, 0, 1.
// A stalled result holds in the accumulator until inverse_ready.
`timescale 1ns / 1ps
`default_nettype none
module modular_inverse_by_exponentiation #(
    parameter int WORD_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_valid,
    output logic             key_ready,
    input  wire logic [63:0] key,
    output logic             inverse_valid,
    input  wire logic        inverse_ready,
    output logic [63:0]      inverse,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import mie_pkg::*;

    logic [63:0]          modulus_reg;
    logic                 composite_reg;
    logic [63:0]          totient_reg;
    logic [WORD_BITS-1:0] m_w, t_w, exponent, acc;
    logic                 mod_small;
    mie_cmd_t             cmd;
    mie_status_t          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= 64'd2;
            composite_reg <= 1'b0;
            totient_reg   <= 64'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODULUS:   modulus_reg   <= cfg_data;
                CFG_COMPOSITE: composite_reg <= cfg_data[0];
                CFG_TOTIENT:   totient_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_w       = modulus_reg[WORD_BITS-1:0];
    assign t_w       = totient_reg[WORD_BITS-1:0];
    assign mod_small = (m_w < WORD_BITS'(2));
    assign exponent  = composite_reg ? (t_w - WORD_BITS'(1)) : (m_w - WORD_BITS'(2));

    mie_controller #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_ready     (key_ready),
        .inverse_valid (inverse_valid),
        .inverse_ready (inverse_ready),
        .exponent      (exponent),
        .mod_small     (mod_small),
        .status        (status),
        .cmd           (cmd)
    );

    mie_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .key     (key[WORD_BITS-1:0]),
        .modulus (m_w),
        .status  (status),
        .acc     (acc)
    );

    assign inverse = 64'(acc);
endmodule
`default_nettype wire

[src/mie_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "modular_inverse_by_exponentiation_defines.svh"
module mie_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        key_valid,
    input wire logic        key_ready,
    input wire logic        inverse_valid,
    input wire logic        inverse_ready,
    input wire logic [63:0] inverse
);
    logic out_stall;

    assign out_stall = inverse_valid && !inverse_ready;

    `MIE_ASSERT_IMPL(a_excl, clk, rst_n, inverse_valid, !key_ready)
    `MIE_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, inverse_valid && $stable(inverse))
    `MIE_ASSERT_NEXT(a_busy, clk, rst_n, key_valid && key_ready, !key_ready)
endmodule

bind modular_inverse_by_exponentiation mie_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .key_valid     (key_valid),
    .key_ready     (key_ready),
    .inverse_valid (inverse_valid),
    .inverse_ready (inverse_ready),
    .inverse       (inverse)
);
`default_nettype wire

[verif/modular_inverse_by_exponentiation_test.sv]
`timescale 1ns / 1ps
module modular_inverse_by_exponentiation_test;
    import mie_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_ROWS = 31;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [63:0] data;
        bit          known;
        logic [63:0] want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        key_valid = 1'b0;
    logic        key_ready;
    logic [63:0] key = '0;
    logic        inverse_valid;
    logic        inverse_ready = 1'b0;
    logic [63:0] inverse;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    logic [63:0] modulus_r = 64'd2;
    logic        composite_r = 1'b0;
    logic [63:0] totient_r = 64'd1;

    logic [63:0] inverse_q[$];
    row_t        rows[N_ROWS];
    int          errors = 0;
    int          cycles = 0;
    int          hold_cycles = 0;
    bit          calm = 1'b0;

    modular_inverse_by_exponentiation DUT (
        .clk(clk), .rst_n(rst_n),
        .key_valid(key_valid), .key_ready(key_ready), .key(key),
        .inverse_valid(inverse_valid), .inverse_ready(inverse_ready), .inverse(inverse),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("modular_inverse_by_exponentiation test failed");
            $finish;
        end
    end

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] predict_inverse(logic [63:0] k);
        logic [63:0] e;
        logic [63:0] base;
        logic [63:0] acc;
        if (modulus_r < 64'd2)
            return 64'd0;
        e = composite_r ? totient_r - 64'd1 : modulus_r - 64'd2;
        base = k % modulus_r;
        acc = 64'd1;
        for (int i = 63; i >= 0; i--)
        begin
            acc = mulmod(acc, acc, modulus_r);
            if (e[i])
                acc = mulmod(acc, base, modulus_r);
        end
        return acc;
    endfunction

    // receiver: random stalls, calm stretch, long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            inverse_ready <= 1'b0;
            hold_cycles--;
        end
        else
            inverse_ready <= calm || ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        if (rst_n && inverse_valid && inverse_ready)
        begin
            if (inverse_q.size() == 0)
            begin
                $display("%0t: unexpected inverse, actual %h", $time, inverse);
                errors++;
            end
            else
            begin
                if (inverse !== inverse_q[0])
                begin
                    $display("%0t: inverse mismatch, expected %h actual %h",
                             $time, inverse_q[0], inverse);
                    errors++;
                end
                void'(inverse_q.pop_front());
            end
        end
    end

    task automatic send_key(logic [63:0] k, bit known, logic [63:0] want);
        cfg_valid <= 1'b0;
        while (!calm && $urandom_range(99) < 34)
        begin
            key_valid <= 1'b0;
            @(negedge clk);
        end
        key_valid <= 1'b1;
        key <= k;
        do @(posedge clk); while (!key_ready);
        inverse_q = {inverse_q, (known ? want : predict_inverse(k))};
        @(negedge clk);
    endtask

    task automatic drain();
        key_valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MODULUS:   modulus_r = data;
            CFG_COMPOSITE: composite_r = data[0];
            CFG_TOTIENT:   totient_r = data;
            default:       ;
        endcase
        @(negedge clk);
    endtask

    function automatic row_t rk(logic [63:0] k, bit known, logic [63:0] want);
        row_t r;
        r.is_cfg = 1'b0; r.idx = '0; r.data = k; r.known = known; r.want = want;
        return r;
    endfunction

    function automatic row_t rc(logic [1:0] idx, logic [63:0] data);
        row_t r;
        r.is_cfg = 1'b1; r.idx = idx; r.data = data; r.known = 1'b0; r.want = '0;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(3))
            0: return 64'($urandom_range(300, 2));
            1: return rand64() | 64'h8000_0000_0000_0000;
            2: return rand64() >> $urandom_range(62);
            default: return ALL_ONES - 64'($urandom_range(100));
        endcase
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(5))
            0: return modulus_r * 64'($urandom_range(3));
            1: return 64'($urandom_range(20, 1));
            2: return ALL_ONES;
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        rows = '{
            rk(64'd5, 1, 64'd1), rk(ALL_ONES, 1, 64'd1),
            rc(CFG_MODULUS, 64'd0), rk(64'd123, 1, 64'd0),
            rc(CFG_MODULUS, 64'd1), rk(64'd7, 1, 64'd0),
            rc(CFG_UNUSED, 64'd5), rk(64'd9, 1, 64'd0),
            rc(CFG_MODULUS, 64'd13), rk(64'd13, 1, 64'd0), rk(64'd3, 1, 64'd9),
            rk(64'd1, 1, 64'd1),
            rc(CFG_MODULUS, ALL_ONES), rk(64'h8000_0000_0000_0000, 0, 0),
            rc(CFG_COMPOSITE, 64'd1), rc(CFG_TOTIENT, 64'd1), rk(ALL_ONES, 1, 64'd1),
            rc(CFG_TOTIENT, 64'd0), rk(64'd2, 0, 0),
            rc(CFG_MODULUS, 64'd15), rc(CFG_TOTIENT, 64'd8),
            rk(64'd2, 1, 64'd8), rk(64'd6, 0, 0),
            rc(CFG_TOTIENT, ALL_ONES), rk(64'h0000_FFFF_0000_FFFF, 0, 0),
            rc(CFG_COMPOSITE, 64'd0), rc(CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFC5),
            rk(64'd1, 1, 64'd1), rk(ALL_ONES, 0, 0),
            rk(64'h5555_AAAA_5555_AAAA, 0, 0), rk(64'hAAAA_5555_AAAA_5555, 0, 0)
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
                send_key(rows[i].data, rows[i].known, rows[i].want);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            write_reg(CFG_MODULUS, rand_operand());
            write_reg(CFG_COMPOSITE, 64'($urandom_range(1)));
            write_reg(CFG_TOTIENT, rand_operand());
            if (phase == 1)
                write_reg(CFG_UNUSED, rand64());
            calm = (phase == 2);
            if (phase == 3)
                hold_cycles = 30000;
            for (int n = 0; n < 14; n++)
            begin
                if (phase == 4 && n == 7)
                    drain();
                send_key(rand_key(), 0, 0);
            end
        end
        calm = 1'b0;
        key_valid <= 1'b0;
        cfg_valid <= 1'b0;

        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("modular_inverse_by_exponentiation test passed");
        else
            $display("modular_inverse_by_exponentiation test failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/mie_pkg.sv
src/mie_datapath.sv
src/mie_controller.sv
src/modular_inverse_by_exponentiation.sv
src/mie_checker.sv
verif/modular_inverse_by_exponentiation_test.sv
